// File: sv/cpf_pkg.sv
// Shared types, constants and the CRC-32 byte update for the packet framer.
package cpf_pkg;

   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [31:0] FRAME_PREFIX = 32'h0000_55AA;
   localparam logic [31:0] FRAME_SUFFIX = 32'h0000_AA55;
   localparam logic [31:0] LENGTH_BIAS  = 32'd8;
   localparam logic [3:0]  HEADER_LAST  = 4'd15;
   localparam logic [3:0]  TRAILER_LAST = 4'd7;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [31:0] message_code;
      logic [15:0] payload_length;
      logic        last_byte;
      logic        first_byte;
      logic [31:0] sequence_number;
   } entry_type;

   typedef enum logic [2:0] {
      ST_PAYLOAD = 3'b001,
      ST_HEADER  = 3'b010,
      ST_TRAILER = 3'b100
   } back_state_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
      logic [7:0] b;
      unique case (sel)
         2'd0:    b = w[31:24];
         2'd1:    b = w[23:16];
         2'd2:    b = w[15:8];
         default: b = w[7:0];
      endcase
      return b;
   endfunction

endpackage

// File: sv/cpf_req_if.sv
// Payload byte channel into the packet framer.
interface cpf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic [31:0] message_code;
   logic [15:0] payload_length;
   logic        last_byte;

   modport source (output valid, data_byte, message_code, payload_length, last_byte,
                   input ready);
   modport sink   (input valid, data_byte, message_code, payload_length, last_byte,
                   output ready);
endinterface

// File: sv/cpf_rsp_if.sv
// Framed byte channel out of the packet framer.
interface cpf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;

   modport source (output valid, out_byte, frame_end, input ready);
   modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// File: sv/cpf_front.sv
// Front end: accepts payload beats, marks frame starts and assigns sequence numbers.
module cpf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_data_byte,
   input  logic [31:0]       in_message_code,
   input  logic [15:0]       in_payload_length,
   input  logic              in_last_byte,
   input  logic              q_full,
   output logic              push,
   output cpf_pkg::entry_type push_entry
);

   logic        frame_open_ff;
   logic        frame_open_in;
   logic [31:0] seq_ff;
   logic [31:0] seq_in;

   always_comb begin
      in_ready                   = !q_full;
      push                       = in_valid && !q_full;
      push_entry.data_byte       = in_data_byte;
      push_entry.message_code    = in_message_code;
      push_entry.payload_length  = in_payload_length;
      push_entry.last_byte       = in_last_byte;
      push_entry.first_byte      = !frame_open_ff;
      push_entry.sequence_number = seq_ff;
      frame_open_in              = frame_open_ff;
      seq_in                     = seq_ff;
      if (push) begin
         frame_open_in = !in_last_byte;
         if (!frame_open_ff) begin
            seq_in = seq_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         seq_ff        <= 32'd1;
      end else begin
         frame_open_ff <= frame_open_in;
         seq_ff        <= seq_in;
      end
   end

endmodule

// File: sv/cpf_queue.sv
// Two-entry queue between the front end and the serializer.
module cpf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cpf_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output cpf_pkg::entry_type head_entry,
   output logic [1:0]         count
);

   cpf_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      full       = (count_ff == 2'd2);
      head_valid = (count_ff != 2'd0);
      head_entry = slot_ff[rd_ptr_ff];
      count      = count_ff;
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: sv/cpf_back.sv
// Back end: serializes header, payload and trailer bytes and runs the CRC-32.
module cpf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  cpf_pkg::entry_type head_entry,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_frame_end
);

   cpf_pkg::back_state_type state_ff;
   cpf_pkg::back_state_type state_in;
   logic [3:0]  idx_ff;
   logic [3:0]  idx_in;
   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic        hdr_done_ff;
   logic        hdr_done_in;
   logic        valid_ff;
   logic        valid_in;
   logic [7:0]  byte_ff;
   logic        end_ff;

   logic        need_hdr;
   logic        emit_hdr;
   logic        slot_free;
   logic        fire;
   logic [31:0] hdr_word;
   logic [31:0] trl_word;
   logic [7:0]  cur_byte;
   logic        cur_end;
   logic [31:0] crc_next;

   always_comb begin
      need_hdr  = (state_ff == cpf_pkg::ST_PAYLOAD) && head_entry.first_byte && !hdr_done_ff;
      emit_hdr  = (state_ff == cpf_pkg::ST_HEADER) || need_hdr;
      slot_free = !valid_ff || out_ready;
      fire      = head_valid && slot_free;

      unique case (idx_ff[3:2])
         2'd0:    hdr_word = cpf_pkg::FRAME_PREFIX;
         2'd1:    hdr_word = head_entry.sequence_number;
         2'd2:    hdr_word = head_entry.message_code;
         default: hdr_word = {16'd0, head_entry.payload_length} + cpf_pkg::LENGTH_BIAS;
      endcase
      trl_word = idx_ff[2] ? cpf_pkg::FRAME_SUFFIX : ~crc_ff;

      cur_end = 1'b0;
      if (emit_hdr) begin
         cur_byte = cpf_pkg::word_byte(hdr_word, idx_ff[1:0]);
      end else if (state_ff == cpf_pkg::ST_TRAILER) begin
         cur_byte = cpf_pkg::word_byte(trl_word, idx_ff[1:0]);
         cur_end  = (idx_ff == cpf_pkg::TRAILER_LAST);
      end else begin
         cur_byte = head_entry.data_byte;
      end
      crc_next = cpf_pkg::crc_byte(crc_ff, cur_byte);

      state_in    = state_ff;
      idx_in      = idx_ff;
      crc_in      = crc_ff;
      hdr_done_in = hdr_done_ff;
      pop         = 1'b0;
      valid_in    = out_ready ? 1'b0 : valid_ff;

      if (fire) begin
         valid_in = 1'b1;
         if (emit_hdr) begin
            crc_in = crc_next;
            if (idx_ff == cpf_pkg::HEADER_LAST) begin
               state_in    = cpf_pkg::ST_PAYLOAD;
               idx_in      = 4'd0;
               hdr_done_in = 1'b1;
            end else begin
               state_in = cpf_pkg::ST_HEADER;
               idx_in   = idx_ff + 4'd1;
            end
         end else begin
            unique case (state_ff)
               cpf_pkg::ST_TRAILER: begin
                  if (cur_end) begin
                     state_in    = cpf_pkg::ST_PAYLOAD;
                     idx_in      = 4'd0;
                     crc_in      = cpf_pkg::CRC_INIT;
                     hdr_done_in = 1'b0;
                     pop         = 1'b1;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
               default: begin
                  crc_in = crc_next;
                  if (head_entry.last_byte) begin
                     state_in = cpf_pkg::ST_TRAILER;
                     idx_in   = 4'd0;
                  end else begin
                     hdr_done_in = 1'b0;
                     pop         = 1'b1;
                  end
               end
            endcase
         end
      end

      out_valid     = valid_ff;
      out_byte      = byte_ff;
      out_frame_end = end_ff;
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= cur_byte;
         end_ff  <= cur_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cpf_pkg::ST_PAYLOAD;
         idx_ff      <= 4'd0;
         crc_ff      <= cpf_pkg::CRC_INIT;
         hdr_done_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         crc_ff      <= crc_in;
         hdr_done_ff <= hdr_done_in;
         valid_ff    <= valid_in;
      end
   end

endmodule

// File: sv/crc32_packet_framer.sv
// Packet framer top level: payload beats in, framed bytes with CRC-32 trailer out.
//
// Each accepted payload beat yields one output beat, plus a 16-byte header
// (00 00 55 AA, sequence number, message code, length + 8) on the first beat
// of a frame and an 8-byte trailer (CRC-32, 00 00 AA 55) on the beat marked
// last. While the receiver is ready, the output port moves one byte per
// cycle, so mid-frame beats go through at one per cycle. A two-entry queue
// sits between the input side and the serializer, and a registered output
// stage lets a new byte load as the previous one is taken, but not while
// it waits. An input beat passes through a queue slot and then the output
// register before its first output byte appears.
module crc32_packet_framer (
   input logic        clock,
   input logic        reset,
   cpf_req_if.sink    req,
   cpf_rsp_if.source  rsp
);

   logic               push;
   logic               q_full;
   cpf_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   cpf_pkg::entry_type head_entry;
   logic [1:0]         q_count;

   cpf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (req.valid),
      .in_ready          (req.ready),
      .in_data_byte      (req.data_byte),
      .in_message_code   (req.message_code),
      .in_payload_length (req.payload_length),
      .in_last_byte      (req.last_byte),
      .q_full            (q_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   cpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .count      (q_count)
   );

   cpf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .out_valid     (rsp.valid),
      .out_ready     (rsp.ready),
      .out_byte      (rsp.out_byte),
      .out_frame_end (rsp.frame_end)
   );

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      q_count != 2'd3)
      else $error("queue count out of range");

   a_ready_full : assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> q_count == 2'd2)
      else $error("input stalled with queue space free");

   a_end_byte : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.frame_end |-> rsp.out_byte == cpf_pkg::FRAME_SUFFIX[7:0])
      else $error("frame end on wrong byte");

   a_pop_has_entry : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

endmodule
